// ===== hdl/backend_failover_circuit_breaker_assert.svh =====
// Assertion macros used by the failover selector datapath.
`ifndef BACKEND_FAILOVER_CIRCUIT_BREAKER_ASSERT_SVH
`define BACKEND_FAILOVER_CIRCUIT_BREAKER_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define BFCB_ASSERT_ALWAYS(lbl, ck, rn, cond) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (cond)) \
        else $error("bfcb invariant violated");

// Condition that must hold in the same cycle whenever the trigger holds.
`define BFCB_ASSERT_IMPLIES(lbl, ck, rn, pre, post) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (pre) |-> (post)) \
        else $error("bfcb implication violated");

`endif

// ===== hdl/bfcb_pkg.sv =====
// Types, codes and constants of the backend failover selector.
package bfcb_pkg;

    localparam int MAX_BACKENDS    = 16;
    localparam int TIME_BITS       = 48;
    localparam int FAIL_COUNT_BITS = 8;

    localparam int IDX_W     = $clog2(MAX_BACKENDS);
    localparam int CNT_W     = $clog2(MAX_BACKENDS + 1);
    localparam int CFG_IDX_W = 2;
    localparam int KIND_W    = 3;
    localparam int HEALTH_W  = 2;
    localparam int REQ_W     = 2;

    localparam logic [FAIL_COUNT_BITS-1:0] FAIL_MAX = '1;

    // Register reset values
    localparam logic [FAIL_COUNT_BITS-1:0] THRESH_RST = FAIL_COUNT_BITS'(2);
    localparam logic [TIME_BITS-1:0]       COOL_RST   = TIME_BITS'(30 * 1000);
    localparam logic [CNT_W-1:0]           LIMIT_RST  = CNT_W'(3);
    localparam logic [CNT_W-1:0]           COUNT_RST  = CNT_W'(MAX_BACKENDS);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COOL_DOWN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TRIES = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT     = 2'd3;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_START   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_OUTCOME = 2'd1;
    localparam logic [REQ_W-1:0] REQ_STATUS  = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_TRY        = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SERVED     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ALL_FAILED = 3'd2;
    localparam logic [KIND_W-1:0] KIND_STATUS     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_IGNORED    = 3'd4;

    // Health codes
    localparam logic [HEALTH_W-1:0] HEALTH_OK        = 2'd0;
    localparam logic [HEALTH_W-1:0] HEALTH_DEGRADED  = 2'd1;
    localparam logic [HEALTH_W-1:0] HEALTH_HALF_OPEN = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_LOAD,
        ST_UPDATE,
        ST_SCAN,
        ST_OFFER,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic turn_reset;
        logic addr_pick;
        logic addr_query;
        logic scan_init;
        logic scan_run;
        logic res_ignored;
        logic res_status;
        logic res_served;
        logic fail_update;
        logic offer;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             ok;
        logic             turn_active;
        logic             scan_done;
        logic             out_busy;
    } dp_stat_t;

endpackage

// ===== hdl/bfcb_ctrl.sv =====
// Sequencing state machine of the failover selector.
module bfcb_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bfcb_pkg::dp_stat_t stat,
    output bfcb_pkg::dp_cmd_t  cmd
);
    import bfcb_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (stat.req)
                    REQ_START:   state_next = ST_SCAN;
                    REQ_OUTCOME: state_next = stat.turn_active ? ST_LOAD : ST_EMIT;
                    REQ_STATUS:  state_next = ST_LOAD;
                    default:     state_next = ST_EMIT;
                endcase
            end
            ST_LOAD:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (stat.req == REQ_STATUS || stat.ok)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = ST_OFFER;
                end
            end
            ST_OFFER:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!stat.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_DECODE:
            begin
                case (stat.req)
                    REQ_START:
                    begin
                        cmd.turn_reset = 1'b1;
                        cmd.scan_init  = 1'b1;
                    end
                    REQ_OUTCOME:
                    begin
                        cmd.addr_pick   = stat.turn_active;
                        cmd.res_ignored = !stat.turn_active;
                    end
                    REQ_STATUS:
                    begin
                        cmd.addr_query = 1'b1;
                    end
                    default:
                    begin
                        cmd.res_ignored = 1'b1;
                    end
                endcase
            end
            ST_UPDATE:
            begin
                if (stat.req == REQ_STATUS)
                begin
                    cmd.res_status = 1'b1;
                end
                else if (stat.ok)
                begin
                    cmd.res_served = 1'b1;
                end
                else
                begin
                    cmd.fail_update = 1'b1;
                    cmd.scan_init   = 1'b1;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_run = 1'b1;
            end
            ST_OFFER:
            begin
                cmd.offer = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit = !stat.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== hdl/bfcb_datapath.sv =====
// Registers, breaker state, priority scan and result registers of the selector.
`include "backend_failover_circuit_breaker_assert.svh"

module bfcb_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  bfcb_pkg::dp_cmd_t                    cmd,
    output bfcb_pkg::dp_stat_t                   stat,
    input  logic                                 cfg_write,
    input  logic [bfcb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bfcb_pkg::TIME_BITS-1:0]       cfg_data,
    input  logic [bfcb_pkg::REQ_W-1:0]           req_type,
    input  logic [bfcb_pkg::TIME_BITS-1:0]       now_time,
    input  logic                                 try_succeeded,
    input  logic [bfcb_pkg::IDX_W-1:0]           query_index,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output logic [bfcb_pkg::KIND_W-1:0]          result_kind,
    output logic [bfcb_pkg::IDX_W-1:0]           backend_index,
    output logic [bfcb_pkg::HEALTH_W-1:0]        health,
    output logic [bfcb_pkg::FAIL_COUNT_BITS-1:0] failure_count,
    output logic [bfcb_pkg::CNT_W-1:0]           tries_used
);
    import bfcb_pkg::*;

    // Configuration
    logic [FAIL_COUNT_BITS-1:0] thr_reg;
    logic [TIME_BITS-1:0]       cool_reg;
    logic [CNT_W-1:0]           lim_reg;
    logic [CNT_W-1:0]           bc_reg;

    // Captured request
    logic [REQ_W-1:0]     req_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic                 ok_reg;
    logic [IDX_W-1:0]     query_reg;

    // Breaker state
    logic [FAIL_COUNT_BITS-1:0] fail_cnt_reg [MAX_BACKENDS];
    logic                       deg_flag_reg [MAX_BACKENDS];
    logic [TIME_BITS-1:0]       stamp_mem    [MAX_BACKENDS];

    // Turn state
    logic [MAX_BACKENDS-1:0] tried_mask_reg;
    logic [CNT_W-1:0]        tries_reg;
    logic                    turn_reg;
    logic [IDX_W-1:0]        pick_reg;

    // Read port and scan
    logic [IDX_W-1:0]           rd_addr_reg;
    logic [CNT_W-1:0]           issue_cnt_reg;
    logic                       rd_live_reg;
    logic [IDX_W-1:0]           rd_idx_reg;
    logic                       rd_flag_reg;
    logic [FAIL_COUNT_BITS-1:0] rd_cnt_reg;
    logic [TIME_BITS-1:0]       stamp_rd_reg;
    logic                       found_good_reg;
    logic                       found_any_reg;
    logic [IDX_W-1:0]           good_idx_reg;
    logic [IDX_W-1:0]           any_idx_reg;

    // Staged result
    logic [KIND_W-1:0]          res_kind_reg;
    logic [IDX_W-1:0]           res_idx_reg;
    logic [HEALTH_W-1:0]        res_health_reg;
    logic [FAIL_COUNT_BITS-1:0] res_cnt_reg;
    logic [CNT_W-1:0]           res_tries_reg;

    // Output register
    logic                       out_valid_reg;
    logic [KIND_W-1:0]          out_kind_reg;
    logic [IDX_W-1:0]           out_idx_reg;
    logic [HEALTH_W-1:0]        out_health_reg;
    logic [FAIL_COUNT_BITS-1:0] out_cnt_reg;
    logic [CNT_W-1:0]           out_tries_reg;

    logic [CNT_W-1:0]           eff_n;
    logic [CNT_W-1:0]           eff_lim;
    logic                       issue_now;
    logic [TIME_BITS-1:0]       elapsed;
    logic [HEALTH_W-1:0]        rd_health;
    logic [IDX_W-1:0]           offer_pick;
    logic                       offer_take;
    logic [FAIL_COUNT_BITS-1:0] cnt_inc;
    logic                       degrade_hit;
    logic                       in_range;

    // Clamp backend count to 1..MAX_BACKENDS, try limit to the count
    always_comb
    begin
        if (bc_reg == '0)
        begin
            eff_n = CNT_W'(1);
        end
        else if (bc_reg > CNT_W'(MAX_BACKENDS))
        begin
            eff_n = CNT_W'(MAX_BACKENDS);
        end
        else
        begin
            eff_n = bc_reg;
        end
        eff_lim = (lim_reg > eff_n) ? eff_n : lim_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= THRESH_RST;
            cool_reg <= COOL_RST;
            lim_reg  <= LIMIT_RST;
            bc_reg   <= COUNT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_THRESHOLD: thr_reg  <= cfg_data[FAIL_COUNT_BITS-1:0];
                CFG_COOL_DOWN: cool_reg <= cfg_data;
                CFG_MAX_TRIES: lim_reg  <= cfg_data[CNT_W-1:0];
                CFG_COUNT:     bc_reg   <= cfg_data[CNT_W-1:0];
                default:       thr_reg  <= thr_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg   <= req_type;
            now_reg   <= now_time;
            ok_reg    <= try_succeeded;
            query_reg <= query_index;
        end
    end

    assign issue_now = cmd.scan_run && (issue_cnt_reg < eff_n);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_addr_reg   <= '0;
            issue_cnt_reg <= '0;
            rd_live_reg   <= 1'b0;
        end
        else
        begin
            rd_live_reg <= issue_now;
            if (cmd.scan_init)
            begin
                rd_addr_reg   <= '0;
                issue_cnt_reg <= '0;
            end
            else if (cmd.addr_pick)
            begin
                rd_addr_reg <= pick_reg;
            end
            else if (cmd.addr_query)
            begin
                rd_addr_reg <= query_reg;
            end
            else if (issue_now)
            begin
                rd_addr_reg   <= rd_addr_reg + IDX_W'(1);
                issue_cnt_reg <= issue_cnt_reg + CNT_W'(1);
            end
        end
    end

    // Stamp memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.fail_update && degrade_hit)
        begin
            stamp_mem[pick_reg] <= now_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        stamp_rd_reg <= stamp_mem[rd_addr_reg];
        rd_flag_reg  <= deg_flag_reg[rd_addr_reg];
        rd_cnt_reg   <= fail_cnt_reg[rd_addr_reg];
        rd_idx_reg   <= rd_addr_reg;
    end

    assign elapsed = now_reg - stamp_rd_reg;

    always_comb
    begin
        if (!rd_flag_reg)
        begin
            rd_health = HEALTH_OK;
        end
        else if (elapsed >= cool_reg)
        begin
            rd_health = HEALTH_HALF_OPEN;
        end
        else
        begin
            rd_health = HEALTH_DEGRADED;
        end
    end

    // Keep the first untried entry, and the first untried one that is usable
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_good_reg <= 1'b0;
            found_any_reg  <= 1'b0;
            good_idx_reg   <= '0;
            any_idx_reg    <= '0;
        end
        else if (cmd.scan_init)
        begin
            found_good_reg <= 1'b0;
            found_any_reg  <= 1'b0;
        end
        else if (rd_live_reg && !tried_mask_reg[rd_idx_reg])
        begin
            if (!found_any_reg)
            begin
                found_any_reg <= 1'b1;
                any_idx_reg   <= rd_idx_reg;
            end
            if (!found_good_reg && rd_health != HEALTH_DEGRADED)
            begin
                found_good_reg <= 1'b1;
                good_idx_reg   <= rd_idx_reg;
            end
        end
    end

    assign offer_pick  = found_good_reg ? good_idx_reg : any_idx_reg;
    assign offer_take  = (tries_reg < eff_lim) && found_any_reg;
    assign cnt_inc     = (rd_cnt_reg == FAIL_MAX) ? rd_cnt_reg
                                                  : rd_cnt_reg + FAIL_COUNT_BITS'(1);
    assign degrade_hit = cnt_inc >= thr_reg;
    assign in_range    = {1'b0, query_reg} < eff_n;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_BACKENDS; i++)
            begin
                fail_cnt_reg[i] <= '0;
                deg_flag_reg[i] <= 1'b0;
            end
        end
        else if (cmd.res_served)
        begin
            fail_cnt_reg[pick_reg] <= '0;
            deg_flag_reg[pick_reg] <= 1'b0;
        end
        else if (cmd.fail_update)
        begin
            fail_cnt_reg[pick_reg] <= cnt_inc;
            if (degrade_hit)
            begin
                deg_flag_reg[pick_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tried_mask_reg <= '0;
            tries_reg      <= '0;
            turn_reg       <= 1'b0;
            pick_reg       <= '0;
        end
        else if (cmd.turn_reset)
        begin
            // Drop any open turn; the offer reopens it
            tried_mask_reg <= '0;
            tries_reg      <= '0;
            turn_reg       <= 1'b0;
        end
        else if (cmd.res_served)
        begin
            turn_reg <= 1'b0;
        end
        else if (cmd.offer)
        begin
            if (offer_take)
            begin
                tried_mask_reg[offer_pick] <= 1'b1;
                tries_reg                  <= tries_reg + CNT_W'(1);
                pick_reg                   <= offer_pick;
                turn_reg                   <= 1'b1;
            end
            else
            begin
                turn_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_ignored)
        begin
            res_kind_reg   <= KIND_IGNORED;
            res_idx_reg    <= '0;
            res_health_reg <= HEALTH_OK;
            res_cnt_reg    <= '0;
            res_tries_reg  <= '0;
        end
        else if (cmd.res_status)
        begin
            res_kind_reg   <= KIND_STATUS;
            res_idx_reg    <= query_reg;
            res_health_reg <= in_range ? rd_health : HEALTH_OK;
            res_cnt_reg    <= in_range ? rd_cnt_reg : '0;
            res_tries_reg  <= tries_reg;
        end
        else if (cmd.res_served)
        begin
            res_kind_reg   <= KIND_SERVED;
            res_idx_reg    <= pick_reg;
            res_health_reg <= HEALTH_OK;
            res_cnt_reg    <= '0;
            res_tries_reg  <= tries_reg;
        end
        else if (cmd.offer)
        begin
            res_health_reg <= HEALTH_OK;
            res_cnt_reg    <= '0;
            if (offer_take)
            begin
                res_kind_reg  <= KIND_TRY;
                res_idx_reg   <= offer_pick;
                res_tries_reg <= tries_reg + CNT_W'(1);
            end
            else
            begin
                res_kind_reg  <= KIND_ALL_FAILED;
                res_idx_reg   <= '0;
                res_tries_reg <= tries_reg;
            end
        end
    end

    // Output register: load on emit, drop once the transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_kind_reg   <= res_kind_reg;
            out_idx_reg    <= res_idx_reg;
            out_health_reg <= res_health_reg;
            out_cnt_reg    <= res_cnt_reg;
            out_tries_reg  <= res_tries_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign result_kind   = out_kind_reg;
    assign backend_index = out_idx_reg;
    assign health        = out_health_reg;
    assign failure_count = out_cnt_reg;
    assign tries_used    = out_tries_reg;

    assign stat.req         = req_reg;
    assign stat.ok          = ok_reg;
    assign stat.turn_active = turn_reg;
    assign stat.scan_done   = (issue_cnt_reg == eff_n) && !rd_live_reg;
    assign stat.out_busy    = out_valid_reg && !out_ready;

    `BFCB_ASSERT_ALWAYS(a_mask_matches_tries, clk, rst_n, $countones(tried_mask_reg) == 32'(tries_reg))
    `BFCB_ASSERT_IMPLIES(a_pick_marked_tried, clk, rst_n, turn_reg, tried_mask_reg[pick_reg])
    `BFCB_ASSERT_IMPLIES(a_good_implies_any, clk, rst_n, found_good_reg, found_any_reg)

endmodule

// ===== hdl/backend_failover_circuit_breaker.sv =====
// Top level of the backend failover selector with per-backend circuit breakers.
//
//   channel  direction  handshake            payload
//   in       in         in_valid/in_ready    req_type, now_time, try_succeeded, query_index
//   out      out        out_valid/out_ready  result_kind, backend_index, health,
//                                            failure_count, tries_used
//   cfg      in         cfg_write            cfg_index, cfg_data
//
// One item at a time. A start turn and a failed outcome run the priority scan over N, the
// clamped backend count: the scan reads one backend a cycle through the stamp memory's
// single read port. Served and status items skip the scan; ignored items go to emit.
// Reset clears counts, degraded marks and turn state at once; stamps need no clearing.
// A stalled output holds its result while the next item is taken and worked on.
module backend_failover_circuit_breaker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [bfcb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bfcb_pkg::TIME_BITS-1:0]       cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [bfcb_pkg::REQ_W-1:0]           req_type,
    input  logic [bfcb_pkg::TIME_BITS-1:0]       now_time,
    input  logic                                 try_succeeded,
    input  logic [bfcb_pkg::IDX_W-1:0]           query_index,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [bfcb_pkg::KIND_W-1:0]          result_kind,
    output logic [bfcb_pkg::IDX_W-1:0]           backend_index,
    output logic [bfcb_pkg::HEALTH_W-1:0]        health,
    output logic [bfcb_pkg::FAIL_COUNT_BITS-1:0] failure_count,
    output logic [bfcb_pkg::CNT_W-1:0]           tries_used
);
    import bfcb_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    bfcb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bfcb_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .req_type      (req_type),
        .now_time      (now_time),
        .try_succeeded (try_succeeded),
        .query_index   (query_index),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .result_kind   (result_kind),
        .backend_index (backend_index),
        .health        (health),
        .failure_count (failure_count),
        .tries_used    (tries_used)
    );

endmodule
